### hdl/lsm_pkg.sv
// Shared types, codes and frame helpers for the LSS fast-scan master.
package lsm_pkg;

   // Queue between the front and back parts
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Identity store
   localparam int PARTS    = 4;
   localparam int PART_AW  = $clog2(PARTS);

   // Request command codes
   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_FRAME   = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;

   // Received frame filter
   localparam logic [10:0] LSS_RX_ID   = 11'h7e4;
   localparam logic [7:0]  RX_IDENTIFY = 8'h4f;
   localparam logic [7:0]  RX_CFG_ACK  = 8'h11;

   // Transmit command specifiers and fields
   localparam logic [7:0] CS_FASTSCAN      = 8'h51;
   localparam logic [7:0] CS_CONFIGURE     = 8'h11;
   localparam logic [7:0] CS_SWITCH_GLOBAL = 8'h04;
   localparam logic [7:0] RESET_BIT        = 8'h80;
   localparam logic [4:0] TOP_BIT          = 5'h1f;
   localparam logic [7:0] MAX_NODE         = 8'h7f;
   localparam logic [2:0] LAST_PART        = 3'd3;

   // Result status codes
   typedef enum logic [2:0] {
      ST_BUSY       = 3'd0,
      ST_SUCCESS    = 3'd1,
      ST_NO_ANSWER  = 3'd2,
      ST_CFG_NACK   = 3'd3,
      ST_INVALID_ID = 3'd4
   } status_type;

   // Classified events
   typedef enum logic [2:0] {
      EV_START     = 3'd0,
      EV_BAD_START = 3'd1,
      EV_IDENT     = 3'd2,
      EV_CFG       = 3'd3,
      EV_TIMEOUT   = 3'd4
   } event_type;

   // Sequencer phases
   typedef enum logic [5:0] {
      PH_IDLE          = 6'b000001,
      PH_RESET         = 6'b000010,
      PH_CONFIRM_KNOWN = 6'b000100,
      PH_SEARCH        = 6'b001000,
      PH_CONFIRM_FOUND = 6'b010000,
      PH_CONFIGURE     = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  node_id;
      logic [1:0]  known_count;
      logic [31:0] known_vendor;
      logic [31:0] known_product;
      logic [31:0] known_revision;
      logic [10:0] rx_id;
      logic [7:0]  rx_cmd;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [63:0] tx_payload;
      logic [2:0]  scan_status;
      logic [31:0] found_vendor;
      logic [31:0] found_product;
      logic [31:0] found_revision;
      logic [31:0] found_serial;
   } rsp_type;

   // One queued event for the back part
   typedef struct packed {
      event_type   ev;
      logic [6:0]  node;
      logic [1:0]  known_count;
      logic [31:0] known_vendor;
      logic [31:0] known_product;
      logic [31:0] known_revision;
   } entry_type;

   // Fast-scan frame: cs, id number, bit checked, part, next part
   function automatic logic [63:0] scan_frame(logic [31:0] number, logic [7:0] bit_sel,
                                              logic [7:0] part, logic [7:0] next_part);
      return {next_part, part, bit_sel, number, CS_FASTSCAN};
   endfunction

endpackage

### hdl/lsm_front.sv
// Front part: accept request beats and classify them into scan events.
module lsm_front (
   input  logic               req_valid,
   output logic               req_ready,
   input  lsm_pkg::req_type   req_item,
   input  logic               q_full,
   output logic               q_push,
   output lsm_pkg::entry_type q_entry
);

   logic       keep;
   logic       id_ok;
   logic       lss_frame;

   // Accept whenever the queue has room
   assign req_ready = !q_full;

   assign id_ok     = (req_item.node_id != 8'd0) && (req_item.node_id <= lsm_pkg::MAX_NODE);
   assign lss_frame = (req_item.rx_id == lsm_pkg::LSS_RX_ID);

   // Classify the beat; drop unrelated frames and unused commands
   always_comb begin
      keep = 1'b0;
      q_entry.ev = lsm_pkg::EV_TIMEOUT;
      case (req_item.command)
         lsm_pkg::CMD_START: begin
            keep = 1'b1;
            q_entry.ev = id_ok ? lsm_pkg::EV_START : lsm_pkg::EV_BAD_START;
         end
         lsm_pkg::CMD_FRAME: begin
            if (lss_frame && req_item.rx_cmd == lsm_pkg::RX_IDENTIFY) begin
               keep = 1'b1;
               q_entry.ev = lsm_pkg::EV_IDENT;
            end else if (lss_frame && req_item.rx_cmd == lsm_pkg::RX_CFG_ACK) begin
               keep = 1'b1;
               q_entry.ev = lsm_pkg::EV_CFG;
            end
         end
         lsm_pkg::CMD_TIMEOUT: begin
            keep = 1'b1;
            q_entry.ev = lsm_pkg::EV_TIMEOUT;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      q_entry.node           = req_item.node_id[6:0];
      q_entry.known_count    = req_item.known_count;
      q_entry.known_vendor   = req_item.known_vendor;
      q_entry.known_product  = req_item.known_product;
      q_entry.known_revision = req_item.known_revision;
   end

   assign q_push = req_valid && req_ready && keep;

endmodule

### hdl/lsm_queue.sv
// Short event queue between the front and back parts.
module lsm_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  lsm_pkg::entry_type           push_entry,
   output logic                         full,
   input  logic                         pop,
   output logic                         empty,
   output lsm_pkg::entry_type           pop_entry
);

   lsm_pkg::entry_type                     slot_ff [lsm_pkg::QUEUE_DEPTH];
   logic [lsm_pkg::QUEUE_AW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [lsm_pkg::QUEUE_AW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [lsm_pkg::QUEUE_CW-1:0]           count_ff, count_in;

   localparam logic [lsm_pkg::QUEUE_AW-1:0] LAST_SLOT = lsm_pkg::QUEUE_AW'(lsm_pkg::QUEUE_DEPTH - 1);
   localparam logic [lsm_pkg::QUEUE_CW-1:0] FULL_CNT  = lsm_pkg::QUEUE_CW'(lsm_pkg::QUEUE_DEPTH);

   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hdl/lsm_back.sv
// Back part: fast-scan sequencer and registered result stage.
module lsm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  lsm_pkg::entry_type q_entry,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lsm_pkg::rsp_type   rsp_item
);

   lsm_pkg::phase_type              phase_ff, phase_in;
   logic [2:0]                      part_ff, part_in;
   logic [4:0]                      bit_ff, bit_in;
   logic [31:0]                     work_ff, work_in;
   logic [1:0]                      given_ff, given_in;
   logic [6:0]                      target_ff, target_in;
   logic [31:0]                     parts_ff [lsm_pkg::PARTS];
   logic [31:0]                     parts_in [lsm_pkg::PARTS];
   logic                            rsp_valid_ff, rsp_valid_in;
   lsm_pkg::rsp_type                rsp_item_ff, rsp_item_in;
   logic                            advance;
   logic                            has_rsp;
   lsm_pkg::rsp_type                res;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign q_pop   = !q_empty && advance;

   // Sequencer: one event per cycle while the queue holds one and the result stage can advance
   always_comb begin
      logic [31:0] wn;
      logic [2:0]  np;
      phase_in  = phase_ff;
      part_in   = part_ff;
      bit_in    = bit_ff;
      work_in   = work_ff;
      given_in  = given_ff;
      target_in = target_ff;
      parts_in  = parts_ff;
      has_rsp   = 1'b0;
      res       = '0;
      wn        = work_ff | (32'd1 << bit_ff);
      np        = (phase_ff == lsm_pkg::PH_RESET) ? 3'd0 : part_ff + 3'd1;

      if (q_entry.ev == lsm_pkg::EV_BAD_START) begin
         phase_in        = lsm_pkg::PH_IDLE;
         has_rsp         = 1'b1;
         res.scan_status = lsm_pkg::ST_INVALID_ID;
      end else if (q_entry.ev == lsm_pkg::EV_START) begin
         target_in   = q_entry.node;
         given_in    = q_entry.known_count;
         parts_in[0] = q_entry.known_vendor;
         parts_in[1] = q_entry.known_product;
         parts_in[2] = q_entry.known_revision;
         part_in     = 3'd0;
         bit_in      = lsm_pkg::TOP_BIT;
         work_in     = '0;
         phase_in    = lsm_pkg::PH_RESET;
         has_rsp     = 1'b1;
         res.tx_valid   = 1'b1;
         res.tx_payload = lsm_pkg::scan_frame('0, lsm_pkg::RESET_BIT, 8'd0, 8'd0);
      end else begin
         case (phase_ff)
            lsm_pkg::PH_IDLE: begin
               has_rsp = 1'b0;
            end
            lsm_pkg::PH_CONFIGURE: begin
               // Finish on acknowledge or timeout; ignore identify replies
               if (q_entry.ev != lsm_pkg::EV_IDENT) begin
                  phase_in       = lsm_pkg::PH_IDLE;
                  has_rsp        = 1'b1;
                  res.tx_valid   = 1'b1;
                  res.tx_payload = {56'd0, lsm_pkg::CS_SWITCH_GLOBAL};
                  if (q_entry.ev == lsm_pkg::EV_CFG) begin
                     res.scan_status    = lsm_pkg::ST_SUCCESS;
                     res.found_vendor   = parts_ff[0];
                     res.found_product  = parts_ff[1];
                     res.found_revision = parts_ff[2];
                     res.found_serial   = parts_ff[3];
                  end else begin
                     res.scan_status = lsm_pkg::ST_CFG_NACK;
                  end
               end
            end
            lsm_pkg::PH_SEARCH: begin
               // Silence on a bit query means the bit is set
               if (q_entry.ev != lsm_pkg::EV_CFG) begin
                  if (q_entry.ev != lsm_pkg::EV_TIMEOUT) begin
                     wn = work_ff;
                  end
                  work_in      = wn;
                  has_rsp      = 1'b1;
                  res.tx_valid = 1'b1;
                  if (bit_ff == 5'd0) begin
                     phase_in       = lsm_pkg::PH_CONFIRM_FOUND;
                     res.tx_payload = lsm_pkg::scan_frame(wn, 8'd0, 8'(part_ff),
                        (part_ff >= lsm_pkg::LAST_PART) ? 8'd0 : 8'(part_ff) + 8'd1);
                  end else begin
                     bit_in         = bit_ff - 5'd1;
                     res.tx_payload = lsm_pkg::scan_frame(wn, 8'(bit_ff - 5'd1),
                                                          8'(part_ff), 8'(part_ff));
                  end
               end
            end
            lsm_pkg::PH_RESET, lsm_pkg::PH_CONFIRM_KNOWN, lsm_pkg::PH_CONFIRM_FOUND: begin
               // Queries that need an identify reply
               if (q_entry.ev == lsm_pkg::EV_TIMEOUT) begin
                  phase_in        = lsm_pkg::PH_IDLE;
                  has_rsp         = 1'b1;
                  res.scan_status = lsm_pkg::ST_NO_ANSWER;
               end else if (q_entry.ev == lsm_pkg::EV_IDENT) begin
                  if (phase_ff == lsm_pkg::PH_CONFIRM_FOUND) begin
                     parts_in[part_ff[lsm_pkg::PART_AW-1:0]] = work_ff;
                  end
                  part_in      = np;
                  has_rsp      = 1'b1;
                  res.tx_valid = 1'b1;
                  if (np[2]) begin
                     phase_in       = lsm_pkg::PH_CONFIGURE;
                     res.tx_payload = {48'd0, 1'b0, target_ff, lsm_pkg::CS_CONFIGURE};
                  end else if (np < {1'b0, given_ff}) begin
                     phase_in       = lsm_pkg::PH_CONFIRM_KNOWN;
                     res.tx_payload = lsm_pkg::scan_frame(
                        parts_ff[np[lsm_pkg::PART_AW-1:0]], 8'd0, 8'(np), 8'(np) + 8'd1);
                  end else begin
                     phase_in       = lsm_pkg::PH_SEARCH;
                     work_in        = '0;
                     bit_in         = lsm_pkg::TOP_BIT;
                     res.tx_payload = lsm_pkg::scan_frame('0, 8'(lsm_pkg::TOP_BIT),
                                                          8'(np), 8'(np));
                  end
               end
            end
            default: begin
               phase_in = lsm_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Load the result stage when it is free or being drained
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in = q_pop && has_rsp;
         rsp_item_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lsm_pkg::PH_IDLE;
         part_ff      <= '0;
         bit_ff       <= lsm_pkg::TOP_BIT;
         work_ff      <= '0;
         given_ff     <= '0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff  <= phase_in;
            part_ff   <= part_in;
            bit_ff    <= bit_in;
            work_ff   <= work_in;
            given_ff  <= given_in;
            target_ff <= target_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Identity store and result payload carry no reset
   always_ff @(posedge clock) begin
      if (q_pop) begin
         parts_ff <= parts_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### hdl/lss_fastscan_master_top.sv
// Top level of the CANopen LSS fast-scan master sequencer.
//
// Request channel (req_valid/req_ready/req_item) carries one event per beat:
// a scan start with the node id and known identity parts, a received CAN
// frame, or a reply-window timeout. Frames not from the LSS response id or
// with another command byte are dropped at the front.
// Result channel (rsp_valid/rsp_ready/rsp_item) carries zero or one beat per
// event: the next frame to send to id 0x7e5, and the scan status, with the
// found identity on success.
// An accepted request beat is written into the event queue, and its result is then
// loaded into the output register, which the receiver may stall.
// Throughput: the back sequencer takes one event per cycle while the receiver is
// not stalling; a two-entry event queue parts front and back.
// Reset clears the sequencer to idle and empties the queue and the output
// register. While the receiver holds rsp_ready low the result stays put,
// the sequencer halts, and requests keep filling the queue until it is full.
module lss_fastscan_master_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lsm_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lsm_pkg::rsp_type rsp_item
);

   logic               q_full;
   logic               q_empty;
   logic               q_push;
   logic               q_pop;
   lsm_pkg::entry_type push_entry;
   lsm_pkg::entry_type pop_entry;

   lsm_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   lsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .pop_entry  (pop_entry)
   );

   lsm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_entry   (pop_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

`ifndef NO_ASSERTIONS
   // A result without a frame carries an empty payload
   a_idle_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.tx_valid |-> rsp_item.tx_payload == 64'd0)
      else $error("result without frame has nonzero payload");

   // Identity is reported only on success
   a_found_only_success: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.scan_status != lsm_pkg::ST_SUCCESS |->
         rsp_item.found_vendor == 32'd0 && rsp_item.found_product == 32'd0 &&
         rsp_item.found_revision == 32'd0 && rsp_item.found_serial == 32'd0)
      else $error("identity reported without success");

   // A full queue accepts nothing, and a queue pop never runs into a stalled result
   a_pop_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty && (!rsp_valid || rsp_ready))
      else $error("event popped while result stage blocked");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("event pushed into full queue");
`endif

endmodule
